FILE: sv/lpdk_pkg.sv
`timescale 1ns / 1ps

package lpdk_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int LEN_W        = 11;
    localparam int MS_W         = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_CTRL = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;
    localparam logic [1:0] KIND_SENT = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_KEEPALIVE = 3'd1;
    localparam logic [2:0] EV_HS_REPLY  = 3'd2;
    localparam logic [2:0] EV_CTRL_BACK = 3'd3;
    localparam logic [2:0] EV_BAD_LEN   = 3'd4;
    localparam logic [2:0] EV_BAD_TYPE  = 3'd5;
    localparam logic [2:0] EV_RX_TMO    = 3'd6;
    localparam logic [2:0] EV_SEND_KA   = 3'd7;

    localparam logic [15:0] TYPE_KEEPALIVE = 16'd0;
    localparam logic [15:0] TYPE_HS_REPLY  = 16'd1;
    localparam logic [15:0] TYPE_MOUSE_OFF = 16'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RECV_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KA_LEAD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN      = 2'd2;

    localparam logic [MS_W-1:0]  RECV_TIMEOUT_RST = 32'd30000;
    localparam logic [MS_W-1:0]  KA_LEAD_RST      = 32'd5000;
    localparam logic [MS_W-1:0]  THRESHOLD_RST    = 32'd25000;
    localparam logic [LEN_W-1:0] MAX_LEN_RST      = 11'd1024;
    localparam logic [MS_W-1:0]  MS_MAX           = '1;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [2:0] event_res;
        logic       active;
        logic       error;
    } t_frm_res;

endpackage

FILE: sv/lpdk_frame.sv
`timescale 1ns / 1ps

module lpdk_frame (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_byte,
    input  lpdk_pkg::t_cfg_wr  i_cfg,
    output lpdk_pkg::t_frm_res o_res
);

    logic                         r_in_payload, n_in_payload;
    logic [lpdk_pkg::LEN_W-1:0]   r_bytes_left, n_bytes_left;
    logic [31:0]                  r_len, n_len;
    logic [15:0]                  r_type, n_type;
    logic [1:0]                   r_idx, n_idx;
    logic                         r_active, n_active;
    logic                         r_error, n_error;
    logic [lpdk_pkg::LEN_W-1:0]   r_max_len;
    logic [2:0]                   ev;
    logic [lpdk_pkg::LEN_W-1:0]   bl_dec;
    logic [31:0]                  len_new;
    logic [15:0]                  type_new;

    assign bl_dec   = r_bytes_left - lpdk_pkg::LEN_W'(1);
    assign len_new  = {r_len[23:0], i_byte};
    assign type_new = (r_idx < 2'd2) ? {r_type[7:0], i_byte} : r_type;

    always_comb begin
        n_in_payload = r_in_payload;
        n_bytes_left = r_bytes_left;
        n_len        = r_len;
        n_type       = r_type;
        n_idx        = r_idx;
        n_active     = r_active;
        n_error      = r_error;
        ev           = lpdk_pkg::EV_NONE;
        case (i_kind)
            lpdk_pkg::KIND_BYTE: begin
                if (!r_error) begin
                    n_bytes_left = bl_dec;
                    if (!r_in_payload) begin
                        n_len = len_new;
                        if (bl_dec == '0) begin
                            if (len_new < 32'd2 || len_new > 32'(r_max_len)) begin
                                n_error = 1'b1;
                                ev      = lpdk_pkg::EV_BAD_LEN;
                            end else begin
                                n_in_payload = 1'b1;
                                n_bytes_left = len_new[lpdk_pkg::LEN_W-1:0];
                                n_idx        = '0;
                                n_type       = '0;
                            end
                        end
                    end else begin
                        n_type = type_new;
                        if (r_idx < 2'd2) begin
                            n_idx = r_idx + 2'd1;
                        end
                        if (bl_dec == '0) begin
                            case (type_new)
                                lpdk_pkg::TYPE_KEEPALIVE: ev = lpdk_pkg::EV_KEEPALIVE;
                                lpdk_pkg::TYPE_HS_REPLY:  ev = lpdk_pkg::EV_HS_REPLY;
                                lpdk_pkg::TYPE_MOUSE_OFF: begin
                                    if (r_active) begin
                                        n_active = 1'b0;
                                        ev       = lpdk_pkg::EV_CTRL_BACK;
                                    end
                                end
                                default: begin
                                    n_error = 1'b1;
                                    ev      = lpdk_pkg::EV_BAD_TYPE;
                                end
                            endcase
                            n_in_payload = 1'b0;
                            n_bytes_left = lpdk_pkg::LEN_W'(lpdk_pkg::HEADER_BYTES);
                            n_len        = '0;
                            n_idx        = '0;
                            n_type       = '0;
                        end
                    end
                end
            end
            lpdk_pkg::KIND_CTRL: n_active = 1'b1;
            default: ;
        endcase
    end

    assign o_res.event_res = ev;
    assign o_res.active    = n_active;
    assign o_res.error     = n_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_bytes_left <= lpdk_pkg::LEN_W'(lpdk_pkg::HEADER_BYTES);
            r_len        <= '0;
            r_type       <= '0;
            r_idx        <= '0;
            r_active     <= 1'b0;
            r_error      <= 1'b0;
            r_max_len    <= lpdk_pkg::MAX_LEN_RST;
        end else begin
            if (i_fire) begin
                r_in_payload <= n_in_payload;
                r_bytes_left <= n_bytes_left;
                r_len        <= n_len;
                r_type       <= n_type;
                r_idx        <= n_idx;
                r_active     <= n_active;
                r_error      <= n_error;
            end
            if (i_cfg.we && i_cfg.idx == lpdk_pkg::REG_MAX_LEN) begin
                r_max_len <= i_cfg.data[lpdk_pkg::LEN_W-1:0];
            end
        end
    end

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |=> r_error)
        else $error("link error flag cleared without reset");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("payload index past type bytes");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_payload && !r_error) |-> (r_bytes_left != '0))
        else $error("payload in progress with no bytes left");

endmodule

FILE: sv/lpdk_idle.sv
`timescale 1ns / 1ps

module lpdk_idle (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_kind,
    input  lpdk_pkg::t_cfg_wr i_cfg,
    output logic [2:0]        o_event
);

    logic [lpdk_pkg::MS_W-1:0] r_timeout, n_timeout;
    logic [lpdk_pkg::MS_W-1:0] r_lead, n_lead;
    logic [lpdk_pkg::MS_W-1:0] r_threshold, n_threshold;
    logic [lpdk_pkg::MS_W-1:0] r_recv_idle, n_recv_idle;
    logic [lpdk_pkg::MS_W-1:0] r_send_idle, n_send_idle;
    logic                      rx_tmo;
    logic                      ka_due;

    // new count > limit, with the saturated count, is old count >= limit
    // unless the limit itself is the top value
    assign rx_tmo = (r_recv_idle >= r_timeout) && (r_timeout != lpdk_pkg::MS_MAX);
    assign ka_due = (r_send_idle >= r_threshold) && (r_threshold != lpdk_pkg::MS_MAX);

    always_comb begin
        n_timeout = r_timeout;
        n_lead    = r_lead;
        if (i_cfg.we && i_cfg.idx == lpdk_pkg::REG_RECV_TIMEOUT) begin
            n_timeout = i_cfg.data;
        end
        if (i_cfg.we && i_cfg.idx == lpdk_pkg::REG_KA_LEAD) begin
            n_lead = i_cfg.data;
        end
        n_threshold = (n_lead >= n_timeout) ? '0 : n_timeout - n_lead;
    end

    always_comb begin
        n_recv_idle = r_recv_idle;
        n_send_idle = r_send_idle;
        o_event     = lpdk_pkg::EV_NONE;
        case (i_kind)
            lpdk_pkg::KIND_BYTE: n_recv_idle = '0;
            lpdk_pkg::KIND_SENT: n_send_idle = '0;
            lpdk_pkg::KIND_TICK: begin
                if (r_recv_idle != lpdk_pkg::MS_MAX) begin
                    n_recv_idle = r_recv_idle + lpdk_pkg::MS_W'(1);
                end
                if (r_send_idle != lpdk_pkg::MS_MAX) begin
                    n_send_idle = r_send_idle + lpdk_pkg::MS_W'(1);
                end
                if (rx_tmo) begin
                    o_event = lpdk_pkg::EV_RX_TMO;
                end else if (ka_due) begin
                    o_event = lpdk_pkg::EV_SEND_KA;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= lpdk_pkg::RECV_TIMEOUT_RST;
            r_lead      <= lpdk_pkg::KA_LEAD_RST;
            r_threshold <= lpdk_pkg::THRESHOLD_RST;
            r_recv_idle <= '0;
            r_send_idle <= '0;
        end else begin
            r_timeout   <= n_timeout;
            r_lead      <= n_lead;
            r_threshold <= n_threshold;
            if (i_fire) begin
                r_recv_idle <= n_recv_idle;
                r_send_idle <= n_send_idle;
            end
        end
    end

    a_thr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_threshold <= r_timeout)
        else $error("keepalive threshold above receive timeout");

endmodule

FILE: sv/length_prefixed_deframer_keepalive.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat fields (low bit up)                         Handshake
// s_axis    in   tdata: rx_byte[7:0]; tuser: kind[1:0]            tvalid/tready
// m_axis    out  tdata: event_res[2:0], active_side, link_error,  tvalid/tready
//                3 zero bits
// cfg       in   i_cfg_idx, i_cfg_data[31:0]                      i_cfg_we
//
// One beat in, one beat out; a new beat is taken every cycle while m_axis accepts results.
// Each beat passes two registers: input register, then result register.
// Synchronous active-low reset restores register defaults and clears framing and idle state;
// the beat data and result registers are not reset. A stall on m_axis holds the result
// register; s_axis stays ready while the input register can still drain.

module length_prefixed_deframer_keepalive (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // event_res[2:0], active_side, link_error, pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic               r_s1_valid;
    logic [1:0]         r_s1_kind;
    logic [7:0]         r_s1_byte;
    logic               r_s2_valid;
    lpdk_pkg::t_frm_res r_s2_res;
    logic               s2_take;
    logic               s1_fire;
    lpdk_pkg::t_cfg_wr  cfg;
    lpdk_pkg::t_frm_res frm_res;
    lpdk_pkg::t_frm_res n_res;
    logic [2:0]         idle_ev;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign s2_take       = !r_s2_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && s2_take;
    assign s_axis_tready = !r_s1_valid || s2_take;

    lpdk_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_kind  (r_s1_kind),
        .i_byte  (r_s1_byte),
        .i_cfg   (cfg),
        .o_res   (frm_res)
    );

    lpdk_idle u_idle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_kind  (r_s1_kind),
        .i_cfg   (cfg),
        .o_event (idle_ev)
    );

    always_comb begin
        n_res = frm_res;
        if (r_s1_kind == lpdk_pkg::KIND_TICK) begin
            n_res.event_res = idle_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (s2_take) begin
                r_s2_valid <= r_s1_valid;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_kind <= s_axis_tuser;
            r_s1_byte <= s_axis_tdata;
        end
        if (s1_fire) begin
            r_s2_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = {3'b000, r_s2_res.error, r_s2_res.active, r_s2_res.event_res};

endmodule
